[rtl/core/hcme_pkg.sv]
// shared types, constants and symbol mapping functions for the mod-37 hill cipher encryptor
// no dependencies; imported by every module under rtl/core
`timescale 1ns / 1ps

package hcme_pkg;

   // symbol alphabet: A-Z, 0-9, space
   localparam int SYM_W = 6;
   localparam logic [SYM_W-1:0] SYM_MOD    = 6'd37;
   localparam logic [SYM_W-1:0] SYM_SPACE  = 6'd36;
   localparam logic [SYM_W-1:0] SYM_DIGIT0 = 6'd26;

   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_Z     = 8'h5a;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // key storage: four rows of four 6-bit entries
   localparam int KEY_ROWS  = 4;
   localparam int KEY_COLS  = 4;
   localparam int KEY_W     = 24;
   localparam int KEY_IDX_W = 2;

   // block control fields are sized for block sizes up to 8
   localparam int ROW_W = 3;
   localparam int CNT_W = 4;

   // cell datapath: acc + key * symbol fits in 12 bits
   localparam int SUM_W     = 12;
   localparam int RED_STEPS = 7;

   // register map
   localparam int ADDR_W = 5;
   localparam int IDX_W  = 3;
   localparam logic [IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
   localparam logic [IDX_W-1:0] REG_KEY_ROW0   = 3'd1;
   localparam logic [IDX_W-1:0] REG_KEY_ROW1   = 3'd2;
   localparam logic [IDX_W-1:0] REG_KEY_ROW2   = 3'd3;
   localparam logic [IDX_W-1:0] REG_KEY_ROW3   = 3'd4;

   localparam logic [2:0]       BLOCK_SIZE_RST = 3'd1;
   localparam logic [KEY_W-1:0] KEY_ROW0_RST   = 24'd1;
   localparam logic [KEY_W-1:0] KEY_ROW1_RST   = 24'd64;
   localparam logic [KEY_W-1:0] KEY_ROW2_RST   = 24'd4096;
   localparam logic [KEY_W-1:0] KEY_ROW3_RST   = 24'd262144;

   // control that travels with each key row along the cell chain
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [CNT_W-1:0] n;
   } ctl_type;

   function automatic logic [SYM_W-1:0] char_to_sym(input logic [7:0] c);
      logic [SYM_W-1:0] s;
      if (c inside {[CH_A:CH_Z]}) begin
         s = SYM_W'(c - CH_A);
      end else if (c inside {[CH_0:CH_9]}) begin
         s = SYM_W'(c - CH_0) + SYM_DIGIT0;
      end else begin
         s = SYM_SPACE;
      end
      return s;
   endfunction

   function automatic logic [7:0] sym_to_char(input logic [SYM_W-1:0] v);
      logic [7:0] c;
      if (v < SYM_DIGIT0) begin
         c = CH_A + 8'(v);
      end else if (v < SYM_SPACE) begin
         c = CH_0 + 8'(v - SYM_DIGIT0);
      end else begin
         c = CH_SPACE;
      end
      return c;
   endfunction

endpackage

[rtl/core/hcme_cell.sv]
// one column cell of the matrix-vector chain: adds key[row][COL] * symbol[COL] mod 37
// depends on hcme_pkg; instantiated MAX_BLOCK times in hill_cipher_mod37_encrypt
`timescale 1ns / 1ps

module hcme_cell #(
   parameter int MAX_BLOCK = 4,
   parameter int COL       = 0
) (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    adv,
   input  logic [hcme_pkg::KEY_ROWS-1:0][hcme_pkg::KEY_W-1:0]      key,
   input  hcme_pkg::ctl_type                                       ctl_in,
   input  logic [hcme_pkg::SYM_W-1:0]                              acc_in,
   input  logic [MAX_BLOCK-1:0][hcme_pkg::SYM_W-1:0]               vec_in,
   output hcme_pkg::ctl_type                                       ctl_out,
   output logic [hcme_pkg::SYM_W-1:0]                              acc_out,
   output logic [MAX_BLOCK-1:0][hcme_pkg::SYM_W-1:0]               vec_out
);
   import hcme_pkg::*;

   logic [KEY_W-1:0]                 key_sel;
   logic [SYM_W-1:0]                 key_ent;
   logic [SUM_W-1:0]                 prod;
   logic [SUM_W-1:0]                 sum_a_in;
   logic [SYM_W-1:0]                 acc_b_in;

   ctl_type                          ctl_a_ff;
   logic [SUM_W-1:0]                 sum_a_ff;
   logic [MAX_BLOCK-1:0][SYM_W-1:0]  vec_a_ff;
   ctl_type                          ctl_b_ff;
   logic [SYM_W-1:0]                 acc_b_ff;
   logic [MAX_BLOCK-1:0][SYM_W-1:0]  vec_b_ff;

   // rows beyond the stored key read as zero
   assign key_sel = (ctl_in.row < ROW_W'(KEY_ROWS)) ? key[ctl_in.row[KEY_IDX_W-1:0]] : '0;

   if (COL < KEY_COLS) begin : g_key
      assign key_ent = key_sel[SYM_W*COL +: SYM_W];
   end else begin : g_nokey
      assign key_ent = '0;
   end

   // columns at or past the block size contribute nothing
   always_comb begin
      if (CNT_W'(COL) < ctl_in.n) begin
         prod = SUM_W'(key_ent) * SUM_W'(vec_in[COL]);
      end else begin
         prod = '0;
      end
      sum_a_in = SUM_W'(acc_in) + prod;
   end

   // restoring reduction mod 37, one conditional subtract per power of two
   always_comb begin
      logic [SUM_W-1:0] r;
      r = sum_a_ff;
      for (int k = RED_STEPS - 1; k >= 0; k--) begin
         if (r >= (SUM_W'(SYM_MOD) << k)) begin
            r = r - (SUM_W'(SYM_MOD) << k);
         end
      end
      acc_b_in = SYM_W'(r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
      end else if (adv) begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_a_ff <= sum_a_in;
         vec_a_ff <= vec_in;
         acc_b_ff <= acc_b_in;
         vec_b_ff <= vec_a_ff;
      end
   end

   assign ctl_out = ctl_b_ff;
   assign acc_out = acc_b_ff;
   assign vec_out = vec_b_ff;

endmodule

[rtl/core/hcme_feed.sv]
// input side: maps characters to symbols, gathers blocks, pads on end of text,
// and issues one key row per advancing cycle to the cells; depends on hcme_pkg
`timescale 1ns / 1ps

module hcme_feed #(
   parameter int MAX_BLOCK = 4
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       adv,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   input  logic [7:0]                                 req_tdata,   // char_code
   input  logic                                       req_tlast,   // end_of_text
   input  logic [2:0]                                 block_size,
   output hcme_pkg::ctl_type                          ctl_out,
   output logic [MAX_BLOCK-1:0][hcme_pkg::SYM_W-1:0]  vec_out
);
   import hcme_pkg::*;

   localparam int FILL_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_BLOCK);

   logic [FILL_W-1:0]                fill_ff, fill_in;
   logic [SYM_W-1:0]                 sym_buf_ff [MAX_BLOCK];
   logic                             pend_valid_ff, pend_valid_in;
   logic                             pend_last_ff;
   logic [CNT_W-1:0]                 pend_n_ff;
   logic [MAX_BLOCK-1:0][SYM_W-1:0]  pend_vec_ff;
   logic [ROW_W-1:0]                 row_ff, row_in;

   logic [SYM_W-1:0]                 sym;
   logic [CNT_W-1:0]                 n_eff;
   logic [CNT_W-1:0]                 fill_ext;
   logic                             complete;
   logic                             last_row;
   logic                             accept;
   logic                             issue;
   logic [MAX_BLOCK-1:0][SYM_W-1:0]  blk_vec;

   assign sym      = char_to_sym(req_tdata);
   assign fill_ext = CNT_W'(fill_ff);

   // block size 0 acts as 1, anything above the array size is clamped
   always_comb begin
      if (block_size == 3'd0) begin
         n_eff = CNT_W'(1);
      end else if (CNT_W'(block_size) > MAX_N) begin
         n_eff = MAX_N;
      end else begin
         n_eff = CNT_W'(block_size);
      end
   end

   assign complete   = ((fill_ext + CNT_W'(1)) >= n_eff) || req_tlast;
   assign last_row   = (CNT_W'(row_ff) + CNT_W'(1)) == pend_n_ff;
   // a character that only fills the open block never touches the pending block
   assign req_tready = adv && (!pend_valid_ff || last_row || !complete);
   assign accept     = req_tvalid && req_tready;
   assign issue      = adv && pend_valid_ff;

   // stored symbols, then the new one, then space padding
   always_comb begin
      for (int j = 0; j < MAX_BLOCK; j++) begin
         if (CNT_W'(j) < fill_ext) begin
            blk_vec[j] = sym_buf_ff[j];
         end else if (CNT_W'(j) == fill_ext) begin
            blk_vec[j] = sym;
         end else begin
            blk_vec[j] = SYM_SPACE;
         end
      end
   end

   always_comb begin
      fill_in       = fill_ff;
      pend_valid_in = pend_valid_ff;
      row_in        = row_ff;
      if (issue) begin
         if (last_row) begin
            pend_valid_in = 1'b0;
            row_in        = '0;
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
      if (accept) begin
         if (complete) begin
            fill_in       = '0;
            pend_valid_in = 1'b1;
            row_in        = '0;
         end else begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         row_ff        <= '0;
      end else begin
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sym_buf_ff[fill_ff] <= sym;
      end
      if (accept && complete) begin
         pend_vec_ff  <= blk_vec;
         pend_n_ff    <= n_eff;
         pend_last_ff <= req_tlast;
      end
   end

   always_comb begin
      ctl_out.valid = pend_valid_ff;
      ctl_out.last  = pend_last_ff;
      ctl_out.row   = row_ff;
      ctl_out.n     = pend_n_ff;
   end
   assign vec_out = pend_vec_ff;

   a_row_in_block: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (CNT_W'(row_ff) < pend_n_ff))
      else $error("issued row index past block size");

   a_fill_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && complete) |=> (fill_ff == '0) && pend_valid_ff)
      else $error("completed block did not restart fill");

   a_ready_needs_adv: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> adv)
      else $error("input taken while chain is stalled");

endmodule

[rtl/core/hill_cipher_mod37_encrypt.sv]
// top level of the mod-37 hill cipher encryptor: csr block, input feed, cell chain, output register
// depends on hcme_pkg, hcme_feed and hcme_cell
`timescale 1ns / 1ps
// path: the results of a block leave in row order after the character that completes it, passing
// the feed's pending register, two register stages per column cell, MAX_BLOCK cells, one output register
// throughput: one character and one result per cycle unless the output stalls; a block cut short
// by end of text holds the input for its remaining rows, as the feed issues one key row per cycle
// reset: synchronous, clears fill count, pipeline valids and registers to their defaults

module hill_cipher_mod37_encrypt #(
   parameter int MAX_BLOCK = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,    // [7:0] char_code
   input  logic                          req_tlast,    // end_of_text
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,    // [7:0] cipher_char
   output logic                          rsp_tlast,    // block_done
   output logic                          rsp_tuser,    // [0] message_done
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hcme_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import hcme_pkg::*;

   logic [2:0]                       block_size_ff;
   logic [KEY_ROWS-1:0][KEY_W-1:0]   key_row_ff;
   logic [IDX_W-1:0]                 csr_idx;
   logic                             csr_wr;

   logic                             adv;
   ctl_type                          ctl_c [MAX_BLOCK+1];
   logic [SYM_W-1:0]                 acc_c [MAX_BLOCK+1];
   logic [MAX_BLOCK-1:0][SYM_W-1:0]  vec_c [MAX_BLOCK+1];
   ctl_type                          ctl_t;
   logic                             tail_last;

   logic                             rsp_tvalid_ff;
   logic [7:0]                       rsp_tdata_ff;
   logic                             rsp_tlast_ff;
   logic                             rsp_tuser_ff;

   // configuration port
   assign csr_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_SIZE_RST;
         key_row_ff[0] <= KEY_ROW0_RST;
         key_row_ff[1] <= KEY_ROW1_RST;
         key_row_ff[2] <= KEY_ROW2_RST;
         key_row_ff[3] <= KEY_ROW3_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_BLOCK_SIZE: block_size_ff <= csr_pwdata[2:0];
            REG_KEY_ROW0:   key_row_ff[0] <= csr_pwdata[KEY_W-1:0];
            REG_KEY_ROW1:   key_row_ff[1] <= csr_pwdata[KEY_W-1:0];
            REG_KEY_ROW2:   key_row_ff[2] <= csr_pwdata[KEY_W-1:0];
            REG_KEY_ROW3:   key_row_ff[3] <= csr_pwdata[KEY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_BLOCK_SIZE: csr_prdata = 32'(block_size_ff);
         REG_KEY_ROW0:   csr_prdata = 32'(key_row_ff[0]);
         REG_KEY_ROW1:   csr_prdata = 32'(key_row_ff[1]);
         REG_KEY_ROW2:   csr_prdata = 32'(key_row_ff[2]);
         REG_KEY_ROW3:   csr_prdata = 32'(key_row_ff[3]);
         default:        csr_prdata = '0;
      endcase
   end

   // the whole chain moves when the output register is free or being drained
   assign adv = !rsp_tvalid_ff || rsp_tready;

   hcme_feed #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_feed (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .block_size (block_size_ff),
      .ctl_out    (ctl_c[0]),
      .vec_out    (vec_c[0])
   );

   assign acc_c[0] = '0;

   for (genvar j = 0; j < MAX_BLOCK; j++) begin : g_cell
      hcme_cell #(
         .MAX_BLOCK (MAX_BLOCK),
         .COL       (j)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .key     (key_row_ff),
         .ctl_in  (ctl_c[j]),
         .acc_in  (acc_c[j]),
         .vec_in  (vec_c[j]),
         .ctl_out (ctl_c[j+1]),
         .acc_out (acc_c[j+1]),
         .vec_out (vec_c[j+1])
      );
   end

   assign ctl_t     = ctl_c[MAX_BLOCK];
   assign tail_last = (CNT_W'(ctl_t.row) + CNT_W'(1)) == ctl_t.n;

   // output register parts the chain from the sink
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= ctl_t.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= sym_to_char(acc_c[MAX_BLOCK]);
         rsp_tlast_ff <= tail_last;
         rsp_tuser_ff <= tail_last && ctl_t.last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_msg_ends_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("message end flagged inside a block");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >= CH_A && rsp_tdata <= CH_Z) ||
                      (rsp_tdata >= CH_0 && rsp_tdata <= CH_9) ||
                      (rsp_tdata == CH_SPACE)))
      else $error("cipher character outside the alphabet");

   a_tail_reduced: assert property (@(posedge clock) disable iff (reset)
      ctl_t.valid |-> (acc_c[MAX_BLOCK] < SYM_MOD))
      else $error("chain output not reduced mod 37");

endmodule
